// ===== hw/rtl/text_console_writer_core_defines.svh =====
// Assertion macros shared by the console writer RTL.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// The property must hold at every clock edge outside reset.
`define TCW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The expression must never be true outside reset.
`define TCW_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define TCW_ASSERT(lbl, prop, msg)

`define TCW_NEVER(lbl, expr, msg)

`endif

`endif

// ===== hw/rtl/tcw_pkg.sv =====
package tcw_pkg;

    // Default screen geometry.
    localparam int SCREEN_ROWS_DEF = 25;
    localparam int MAX_COLUMNS_DEF = 80;

    // Field widths of the stream words and the configuration register.
    localparam int CHAR_W     = 8;
    localparam int ATTR_W     = 8;
    localparam int ROW_W      = 5;
    localparam int COL_W      = 7;
    localparam int CFG_W      = 7;
    localparam int CELL_W     = CHAR_W + ATTR_W;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;

    localparam logic [CFG_W-1:0]  COLUMNS_RESET = 7'd80;
    localparam logic [ATTR_W-1:0] ATTR_DEFAULT  = 8'h07;
    localparam logic [CHAR_W-1:0] CH_ESCAPE     = 8'h26;
    localparam logic [CHAR_W-1:0] CH_NEWLINE    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_BLANK      = 8'h00;

    typedef enum logic
    {
        OP_PUT  = 1'b0,
        OP_READ = 1'b1
    } tcw_op_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_EXEC,
        ST_RD_DATA,
        ST_SCROLL,
        ST_DRAIN,
        ST_CLEAR
    } tcw_state_t;

    // Attribute selected by the byte that follows an escape.
    function automatic logic [ATTR_W-1:0] attr_from_byte(input logic [CHAR_W-1:0] b);
        logic [ATTR_W-1:0] a;
        if (b >= 8'h61 && b <= 8'h66)
        begin
            a = b - 8'h61 + 8'd10;
        end
        else if (b >= 8'h30 && b <= 8'h39)
        begin
            a = b - 8'h30;
        end
        else
        begin
            a = ATTR_DEFAULT;
        end
        return a;
    endfunction

endpackage

// ===== hw/rtl/tcw_ram.sv =====
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one read port with registered read data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hw/rtl/text_console_writer_core.sv =====
// A put registers its result word from ST_EXEC; an in-range read goes through ST_RD_DATA first.
// A put that moves the cursor past the last row scrolls through ST_SCROLL, ST_DRAIN and
// ST_CLEAR, one cell copy per cycle through the single screen RAM write port.
// Throughput: one item at a time; the next word is taken once the result register frees.
// Reset (rst_n, asynchronous, active low): cursor at 0/0, attribute 0x07, no escape,
// 80 columns. The screen RAM is not cleared; cells read as undefined until written.
`include "text_console_writer_core_defines.svh"

module text_console_writer_core #(
    parameter int SCREEN_ROWS = tcw_pkg::SCREEN_ROWS_DEF,
    parameter int MAX_COLUMNS = tcw_pkg::MAX_COLUMNS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,

    // Column count register write channel.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tcw_pkg::CFG_W-1:0]       cfg_data,      // columns_in_use

    // Input stream.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // char_code [7:0], read_row [12:8], read_col [19:13], zero [23:20]
    input  logic [tcw_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  logic                            s_axis_tuser,  // operation

    // Result stream.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // cell_char [7:0], cell_attrib [15:8], cursor_col [22:16], cursor_row [27:23],
    // scrolled [28], zero [31:29]
    output logic [tcw_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    import tcw_pkg::*;

    // Widths derived from the screen geometry.
    localparam int RW    = $clog2(SCREEN_ROWS);                 // row index
    localparam int CW    = $clog2(MAX_COLUMNS + 1);             // column, may hold the count
    localparam int AW    = $clog2(SCREEN_ROWS * MAX_COLUMNS);   // screen RAM address
    localparam int DEPTH = SCREEN_ROWS * MAX_COLUMNS;
    localparam int EW    = (CW > CFG_W) ? CW : CFG_W;            // column count compare
    localparam int MRW   = (RW > ROW_W) ? RW : ROW_W;            // multiplier row operand
    localparam int MCW   = (CW > COL_W) ? CW : COL_W;            // multiplier column operand
    localparam int PW    = MRW + CW;                             // product width
    localparam int SW    = AW + 1;                               // scroll address sums

    // Control and architectural state.
    tcw_state_t          state_reg, state_next;
    logic [CFG_W-1:0]    cols_cfg_reg;
    logic [CW-1:0]       cur_col_reg, cur_col_next;
    logic [RW-1:0]       cur_row_reg, cur_row_next;
    logic [ATTR_W-1:0]   attr_reg, attr_next;
    logic                esc_reg, esc_next;

    // The accepted item.
    tcw_op_t             op_reg, op_next;
    logic [CHAR_W-1:0]   char_reg, char_next;
    logic [ROW_W-1:0]    rrow_reg, rrow_next;
    logic [COL_W-1:0]    rcol_reg, rcol_next;

    // Scroll sequencer.
    logic [CW-1:0]       sc_col_reg, sc_col_next;
    logic [RW-1:0]       sc_row_reg, sc_row_next;
    logic [AW-1:0]       base_reg, base_next;
    logic                wpend_reg, wpend_next;
    logic [AW-1:0]       waddr_reg, waddr_next;

    // Result register.
    logic                m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]   o_char_reg, o_char_next;
    logic [ATTR_W-1:0]   o_attr_reg, o_attr_next;
    logic [COL_W-1:0]    o_col_reg, o_col_next;
    logic [ROW_W-1:0]    o_row_reg, o_row_next;
    logic                o_scr_reg, o_scr_next;

    // Screen RAM port signals.
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [CELL_W-1:0]   ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [CELL_W-1:0]   ram_rdata;

    // Combinational helpers.
    logic [EW-1:0]       cfg_ext;
    logic [CW-1:0]       eff_cols;
    logic                rd_in_range;
    logic [MRW-1:0]      mul_row;
    logic [MCW-1:0]      mul_col;
    logic [PW-1:0]       prod;
    logic [PW-1:0]       cell_sum;
    logic [AW-1:0]       cell_addr;
    logic [CW:0]         col_inc;
    logic [CW:0]         sc_col_inc;
    logic                sc_col_last;
    logic [SW-1:0]       src_sum;
    logic [SW-1:0]       dst_sum;
    logic                row_step;
    logic [CW-1:0]       col_new;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE) && (!m_valid_reg || m_axis_tready);

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {3'b000, o_scr_reg, o_row_reg, o_col_reg, o_attr_reg, o_char_reg};

    // The register value is clamped to 1..MAX_COLUMNS before use.
    assign cfg_ext = EW'(cols_cfg_reg);
    always_comb
    begin
        if (cfg_ext == '0)
        begin
            eff_cols = CW'(1);
        end
        else if (cfg_ext > EW'(MAX_COLUMNS))
        begin
            eff_cols = CW'(MAX_COLUMNS);
        end
        else
        begin
            eff_cols = cfg_ext[CW-1:0];
        end
    end

    assign rd_in_range = (32'(rrow_reg) < 32'(SCREEN_ROWS)) && (32'(rcol_reg) < 32'(eff_cols));

    // The one multiplier turns a row and a column into a screen RAM address. It serves
    // the read address of a read and the write address of a put; the scroll sweep walks
    // the rows with a running base address instead.
    assign mul_row   = (op_reg == OP_READ) ? MRW'(rrow_reg) : MRW'(cur_row_reg);
    assign mul_col   = (op_reg == OP_READ) ? MCW'(rcol_reg) : MCW'(cur_col_reg);
    assign prod      = PW'(mul_row) * PW'(MAX_COLUMNS);
    assign cell_sum  = prod + PW'(mul_col);
    assign cell_addr = cell_sum[AW-1:0];

    assign col_inc     = {1'b0, cur_col_reg} + (CW+1)'(1);
    assign sc_col_inc  = {1'b0, sc_col_reg} + (CW+1)'(1);
    assign sc_col_last = (sc_col_inc == {1'b0, eff_cols});

    // During a scroll each cell of row r+1 is read and, in the next cycle when the RAM
    // returns it, written to the same column of row r.
    assign src_sum = SW'(base_reg) + SW'(MAX_COLUMNS) + SW'(sc_col_reg);
    assign dst_sum = SW'(base_reg) + SW'(sc_col_reg);

    always_comb
    begin
        state_next   = state_reg;
        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        attr_next    = attr_reg;
        esc_next     = esc_reg;
        op_next      = op_reg;
        char_next    = char_reg;
        rrow_next    = rrow_reg;
        rcol_next    = rcol_reg;
        sc_col_next  = sc_col_reg;
        sc_row_next  = sc_row_reg;
        base_next    = base_reg;
        wpend_next   = wpend_reg;
        waddr_next   = waddr_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        o_char_next  = o_char_reg;
        o_attr_next  = o_attr_reg;
        o_col_next   = o_col_reg;
        o_row_next   = o_row_reg;
        o_scr_next   = o_scr_reg;
        ram_we       = 1'b0;
        ram_waddr    = cell_addr;
        ram_wdata    = {attr_reg, char_reg};
        ram_raddr    = cell_addr;
        row_step     = 1'b0;
        col_new      = cur_col_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    op_next    = tcw_op_t'(s_axis_tuser);
                    char_next  = s_axis_tdata[7:0];
                    rrow_next  = s_axis_tdata[12:8];
                    rcol_next  = s_axis_tdata[19:13];
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                // Results of a put or of an out-of-range read carry a zero cell.
                o_char_next = '0;
                o_attr_next = '0;
                o_scr_next  = 1'b0;
                if (op_reg == OP_READ)
                begin
                    if (rd_in_range)
                    begin
                        state_next = ST_RD_DATA;
                    end
                    else
                    begin
                        o_col_next   = COL_W'(cur_col_reg);
                        o_row_next   = ROW_W'(cur_row_reg);
                        m_valid_next = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
                else if (esc_reg)
                begin
                    attr_next    = attr_from_byte(char_reg);
                    esc_next     = 1'b0;
                    o_col_next   = COL_W'(cur_col_reg);
                    o_row_next   = ROW_W'(cur_row_reg);
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
                else if (char_reg == CH_ESCAPE)
                begin
                    esc_next     = 1'b1;
                    o_col_next   = COL_W'(cur_col_reg);
                    o_row_next   = ROW_W'(cur_row_reg);
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    if (char_reg == CH_NEWLINE)
                    begin
                        col_new   = '0;
                        row_step  = 1'b1;
                        attr_next = ATTR_DEFAULT;
                    end
                    else
                    begin
                        // A printable byte lands at the cursor, even when a smaller
                        // column count has left the cursor beyond the visible row.
                        ram_we = 1'b1;
                        if (col_inc >= {1'b0, eff_cols})
                        begin
                            col_new  = '0;
                            row_step = 1'b1;
                        end
                        else
                        begin
                            col_new = col_inc[CW-1:0];
                        end
                    end
                    cur_col_next = col_new;
                    if (row_step && (cur_row_reg == RW'(SCREEN_ROWS - 1)))
                    begin
                        // Past the last row: the cursor stays there and the screen moves up.
                        sc_col_next = '0;
                        sc_row_next = '0;
                        base_next   = '0;
                        wpend_next  = 1'b0;
                        state_next  = ST_SCROLL;
                    end
                    else
                    begin
                        cur_row_next = cur_row_reg + RW'(row_step);
                        o_col_next   = COL_W'(col_new);
                        o_row_next   = ROW_W'(cur_row_reg + RW'(row_step));
                        m_valid_next = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
            end

            ST_RD_DATA:
            begin
                o_char_next  = ram_rdata[CHAR_W-1:0];
                o_attr_next  = ram_rdata[CELL_W-1:CHAR_W];
                o_col_next   = COL_W'(cur_col_reg);
                o_row_next   = ROW_W'(cur_row_reg);
                o_scr_next   = 1'b0;
                m_valid_next = 1'b1;
                state_next   = ST_IDLE;
            end

            ST_SCROLL:
            begin
                ram_raddr  = src_sum[AW-1:0];
                ram_we     = wpend_reg;
                ram_waddr  = waddr_reg;
                ram_wdata  = ram_rdata;
                wpend_next = 1'b1;
                waddr_next = dst_sum[AW-1:0];
                if (sc_col_last)
                begin
                    sc_col_next = '0;
                    base_next   = base_reg + AW'(MAX_COLUMNS);
                    if (sc_row_reg == RW'(SCREEN_ROWS - 2))
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        sc_row_next = sc_row_reg + RW'(1);
                    end
                end
                else
                begin
                    sc_col_next = sc_col_inc[CW-1:0];
                end
            end

            ST_DRAIN:
            begin
                // The last copied cell is still on its way out of the RAM.
                ram_we     = wpend_reg;
                ram_waddr  = waddr_reg;
                ram_wdata  = ram_rdata;
                wpend_next = 1'b0;
                state_next = ST_CLEAR;
            end

            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = dst_sum[AW-1:0];
                ram_wdata = {ATTR_DEFAULT, CH_BLANK};
                if (sc_col_last)
                begin
                    o_char_next  = '0;
                    o_attr_next  = '0;
                    o_col_next   = COL_W'(cur_col_reg);
                    o_row_next   = ROW_W'(cur_row_reg);
                    o_scr_next   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    sc_col_next = sc_col_inc[CW-1:0];
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cols_cfg_reg <= COLUMNS_RESET;
            cur_col_reg  <= '0;
            cur_row_reg  <= '0;
            attr_reg     <= ATTR_DEFAULT;
            esc_reg      <= 1'b0;
            wpend_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cur_col_reg <= cur_col_next;
            cur_row_reg <= cur_row_next;
            attr_reg    <= attr_next;
            esc_reg     <= esc_next;
            wpend_reg   <= wpend_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                cols_cfg_reg <= cfg_data;
            end
        end
    end

    // Payload and sequencer data registers need no reset.
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        char_reg   <= char_next;
        rrow_reg   <= rrow_next;
        rcol_reg   <= rcol_next;
        sc_col_reg <= sc_col_next;
        sc_row_reg <= sc_row_next;
        base_reg   <= base_next;
        waddr_reg  <= waddr_next;
        o_char_reg <= o_char_next;
        o_attr_reg <= o_attr_next;
        o_col_reg  <= o_col_next;
        o_row_reg  <= o_row_next;
        o_scr_reg  <= o_scr_next;
    end

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_screen (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    `TCW_ASSERT(a_accept_clears_result, (s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid, "result word pending while an item starts")
    `TCW_ASSERT(a_result_from_busy, $rose(m_valid_reg) |-> $past(state_reg) != ST_IDLE, "result word raised without work")
    `TCW_NEVER(a_no_idle_write, ram_we && (state_reg == ST_IDLE), "screen RAM written while idle")
    `TCW_NEVER(a_row_range, cur_row_reg > RW'(SCREEN_ROWS - 1), "cursor row beyond the last row")
    `TCW_NEVER(a_no_escape_in_scroll, esc_reg && (state_reg == ST_SCROLL || state_reg == ST_CLEAR), "scroll with an escape pending")

endmodule

// ===== test/text_console_writer_core_tb.sv =====
module text_console_writer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    // Screen geometry matches the default parameters of the core.
    localparam int ROWS     = SCREEN_ROWS_DEF;
    localparam int COLS_MAX = MAX_COLUMNS_DEF;

    // A put that scrolls keeps the core busy before its result word is raised:
    // one cell copy per cycle over the whole screen. Every register write and the
    // end of the run wait at least this long once all result words are back.
    localparam int SETTLE_CYCLES = ROWS * COLS_MAX + 64;

    // Watchdog. The slowest correct run scrolls on nearly every put, for roughly
    // 1650 words plus stalls. The limit is set well above what that run takes.
    localparam longint unsigned CYCLE_LIMIT = 20_000_000;

    localparam int PHASE_ITEMS = 230;

    // One result word as the core packs it, cell_char in the lowest bits.
    typedef struct packed
    {
        logic              scrolled;
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_col;
        logic [ATTR_W-1:0] cell_attrib;
        logic [CHAR_W-1:0] cell_char;
    } console_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_W-1:0]       cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata;   // char_code, read_row, read_col, zero pad
    logic                   s_axis_tuser;   // operation
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;   // cell_char, cell_attrib, cursor_col,
                                            // cursor_row, scrolled, zero pad

    text_console_writer_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Result words predicted for accepted input words, oldest first.
    console_result_t pending_results[$];

    // Mirror of the console state. cell_written marks cells that hold a known
    // value, so that random reads never touch a cell the core leaves undefined.
    logic [CELL_W-1:0] screen_mirror [ROWS][COLS_MAX];
    bit                cell_written  [ROWS][COLS_MAX];
    int unsigned       mirror_col;
    int unsigned       mirror_row;
    logic [ATTR_W-1:0] mirror_attr;
    bit                escape_armed;
    logic [CFG_W-1:0]  columns_setting;

    bit              idle_on;
    int unsigned     stall_left = 0;
    int unsigned     error_count = 0;
    int unsigned     items_sent = 0;
    longint unsigned cycle_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // The register value is clamped to 1..MAX_COLUMNS before use.
    function automatic int unsigned active_columns();
        int unsigned cols;
        cols = columns_setting;
        if (cols < 1)
        begin
            cols = 1;
        end
        if (cols > COLS_MAX)
        begin
            cols = COLS_MAX;
        end
        return cols;
    endfunction

    // Byte after an escape: hex digit in lower case selects 0..15, anything else
    // falls back to the default attribute.
    function automatic logic [ATTR_W-1:0] escape_attribute(logic [CHAR_W-1:0] code);
        logic [ATTR_W-1:0] attr;
        if (code inside {[8'h30:8'h39]})
        begin
            attr = code - 8'h30;
        end
        else if (code inside {[8'h61:8'h66]})
        begin
            attr = code - 8'h57;
        end
        else
        begin
            attr = ATTR_DEFAULT;
        end
        return attr;
    endfunction

    // Scroll moves and clears only the columns below the active count; cells
    // beyond it keep whatever they held.
    function automatic void shift_screen_up(int unsigned cols);
        for (int r = 0; r < ROWS - 1; r++)
        begin
            for (int c = 0; c < cols; c++)
            begin
                screen_mirror[r][c] = screen_mirror[r + 1][c];
                cell_written[r][c]  = cell_written[r + 1][c];
            end
        end
        for (int c = 0; c < cols; c++)
        begin
            screen_mirror[ROWS - 1][c] = {ATTR_DEFAULT, CH_BLANK};
            cell_written[ROWS - 1][c]  = 1'b1;
        end
    endfunction

    // Applies one accepted word to the mirror and returns the word the core
    // should answer with.
    function automatic console_result_t console_predict(tcw_op_t op, logic [CHAR_W-1:0] code,
                                                        logic [ROW_W-1:0] row,
                                                        logic [COL_W-1:0] col);
        console_result_t res;
        int unsigned     cols;
        cols = active_columns();
        res  = '0;
        if (op == OP_READ)
        begin
            if (row < ROWS && col < cols)
            begin
                res.cell_char   = screen_mirror[row][col][CHAR_W-1:0];
                res.cell_attrib = screen_mirror[row][col][CELL_W-1:CHAR_W];
            end
        end
        else if (escape_armed)
        begin
            mirror_attr  = escape_attribute(code);
            escape_armed = 1'b0;
        end
        else if (code == CH_ESCAPE)
        begin
            escape_armed = 1'b1;
        end
        else
        begin
            if (code == CH_NEWLINE)
            begin
                mirror_col  = 0;
                mirror_row++;
                mirror_attr = ATTR_DEFAULT;
            end
            else
            begin
                // The cell is written at the cursor even when the count has
                // shrunk below it; it just cannot be read until the count grows.
                if (mirror_col < COLS_MAX && mirror_row < ROWS)
                begin
                    screen_mirror[mirror_row][mirror_col] = {mirror_attr, code};
                    cell_written[mirror_row][mirror_col]  = 1'b1;
                end
                mirror_col++;
                if (mirror_col >= cols)
                begin
                    mirror_col = 0;
                    mirror_row++;
                end
            end
            if (mirror_row >= ROWS)
            begin
                shift_screen_up(cols);
                mirror_row   = ROWS - 1;
                res.scrolled = 1'b1;
            end
        end
        res.cursor_col = mirror_col[COL_W-1:0];
        res.cursor_row = mirror_row[ROW_W-1:0];
        return res;
    endfunction

    // Offers one input word, holding it until the core takes it. The valid line
    // is left high afterwards, so it need not toggle between back-to-back words.
    task automatic send_word(tcw_op_t op, logic [CHAR_W-1:0] code, logic [ROW_W-1:0] row,
                             logic [COL_W-1:0] col);
        int unsigned gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 3);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {{(IN_DATA_W - COL_W - ROW_W - CHAR_W){1'b0}}, col, row, code};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        pending_results.push_back(console_predict(op, code, row, col));
        items_sent++;
    endtask

    // The read fields of a put and the byte of a read are don't-cares, so they
    // carry random values to toggle every input bit.
    task automatic put_char(logic [CHAR_W-1:0] code);
        send_word(OP_PUT, code, $urandom_range(0, 31), $urandom_range(0, 127));
    endtask

    task automatic read_cell(logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
        send_word(OP_READ, $urandom_range(0, 255), row, col);
    endtask

    // Stops offering words and waits until every predicted result has come back.
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Register writes happen only with the core idle: after all result words are
    // back and the settle wait has passed.
    task automatic set_columns(logic [CFG_W-1:0] value);
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        columns_setting = value;
    endtask

    // Picks a read address whose answer is defined: a cell already written, or
    // one outside the visible screen, which always reads as zero.
    task automatic pick_read_cell(output logic [ROW_W-1:0] row, output logic [COL_W-1:0] col);
        int unsigned cols;
        int unsigned r;
        int unsigned c;
        cols = active_columns();
        if ($urandom_range(0, 3) != 0)
        begin
            for (int tries = 0; tries < 16; tries++)
            begin
                r = $urandom_range(0, ROWS - 1);
                c = $urandom_range(0, cols - 1);
                if (cell_written[r][c])
                begin
                    row = r;
                    col = c;
                    return;
                end
            end
        end
        if ($urandom_range(0, 1) == 0)
        begin
            row = $urandom_range(ROWS, 31);
            col = $urandom_range(0, 127);
        end
        else
        begin
            row = $urandom_range(0, 31);
            col = $urandom_range(cols, 127);
        end
    endtask

    // Extremes of the fields, every escape flavor, newline, and reads inside
    // and outside the visible screen, all at the reset column count.
    task automatic test_escapes_and_reads();
        put_char(8'h41);
        read_cell(0, 0);
        put_char(CH_ESCAPE);
        put_char("f");
        put_char(8'hFF);
        put_char(8'h00);
        put_char(CH_ESCAPE);
        put_char("9");
        put_char(CH_ESCAPE);
        put_char("a");
        // An escape followed by another escape, a newline or a zero byte only
        // restores the default attribute; none of them is acted on.
        put_char(CH_ESCAPE);
        put_char(CH_ESCAPE);
        put_char(CH_ESCAPE);
        put_char(CH_NEWLINE);
        put_char(CH_ESCAPE);
        put_char(8'h00);
        put_char(8'h80);
        put_char(CH_NEWLINE);
        read_cell(0, 2);
        read_cell(0, 3);
        read_cell(31, 127);
        read_cell(24, 80);
        read_cell(25, 0);
    endtask

    // Column count clamping and a cursor left beyond a shrunken count.
    task automatic test_column_limits();
        put_char(8'h31);
        put_char(8'h32);
        put_char(8'h33);
        set_columns(7'd2);
        put_char(8'h55);
        read_cell(1, 3);
        set_columns(7'd127);
        read_cell(1, 3);
        set_columns(7'd0);
        put_char(8'h41);
        put_char(8'h42);
        read_cell(mirror_row[ROW_W-1:0] - 5'd1, 0);
    endtask

    // Mostly random byte puts with escape pairs, newlines and reads mixed in;
    // when allowed, idling is switched on and off in stretches, and halfway
    // through the sender holds back until every result is in.
    task automatic run_random_traffic(logic [CFG_W-1:0] cols_value, int unsigned n_items,
                                      bit allow_idle);
        int unsigned      first_item;
        int unsigned      loop_count;
        int unsigned      roll;
        bit               drained_once;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        set_columns(cols_value);
        first_item   = items_sent;
        loop_count   = 0;
        drained_once = 1'b0;
        while (items_sent - first_item < n_items)
        begin
            if (loop_count % 48 == 0)
            begin
                idle_on = allow_idle && ($urandom_range(0, 3) != 0);
            end
            loop_count++;
            if (!drained_once && items_sent - first_item >= n_items / 2)
            begin
                wait_results_drained();
                drained_once = 1'b1;
            end
            roll = $urandom_range(0, 99);
            if (roll < 20)
            begin
                pick_read_cell(row, col);
                read_cell(row, col);
            end
            else if (roll < 30)
            begin
                put_char(CH_ESCAPE);
                case ($urandom_range(0, 3))
                    0: put_char($urandom_range(8'h30, 8'h39));
                    1: put_char($urandom_range(8'h61, 8'h66));
                    2: put_char($urandom_range(8'h41, 8'h46));
                    default: put_char($urandom_range(0, 255));
                endcase
            end
            else if (roll < 38)
            begin
                put_char(CH_NEWLINE);
            end
            else
            begin
                put_char($urandom_range(0, 255));
            end
        end
    endtask

    // Result side: m_axis_tready drops in random stall bursts while idling is on.
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left    <= $urandom_range(0, 2);
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // Checks every accepted result word against the oldest prediction.
    always @(posedge clk)
    begin
        console_result_t got;
        console_result_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got = console_result_t'(m_axis_tdata[$bits(console_result_t)-1:0]);
            if (pending_results.size() == 0)
            begin
                $error("result word with nothing expected: %h", m_axis_tdata);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.cell_char !== want.cell_char)
                begin
                    $error("cell_char: expected %0h, got %0h", want.cell_char, got.cell_char);
                    error_count++;
                end
                if (got.cell_attrib !== want.cell_attrib)
                begin
                    $error("cell_attrib: expected %0h, got %0h", want.cell_attrib,
                           got.cell_attrib);
                    error_count++;
                end
                if (got.cursor_col !== want.cursor_col)
                begin
                    $error("cursor_col: expected %0d, got %0d", want.cursor_col,
                           got.cursor_col);
                    error_count++;
                end
                if (got.cursor_row !== want.cursor_row)
                begin
                    $error("cursor_row: expected %0d, got %0d", want.cursor_row,
                           got.cursor_row);
                    error_count++;
                end
                if (got.scrolled !== want.scrolled)
                begin
                    $error("scrolled: expected %0d, got %0d", want.scrolled, got.scrolled);
                    error_count++;
                end
            end
        end
    end

    // Watchdog.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        rst_n         <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_data      <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_PUT;
        m_axis_tready <= 1'b0;

        mirror_col      = 0;
        mirror_row      = 0;
        mirror_attr     = ATTR_DEFAULT;
        escape_armed    = 1'b0;
        columns_setting = COLUMNS_RESET;
        idle_on         = 1'b1;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_escapes_and_reads();
        test_column_limits();

        // Clamped, boundary and ordinary counts in turn; the last phase runs
        // without any idling on either side.
        run_random_traffic(7'd0, PHASE_ITEMS, 1'b1);
        run_random_traffic(7'd80, PHASE_ITEMS, 1'b1);
        run_random_traffic(7'd1, PHASE_ITEMS, 1'b1);
        run_random_traffic($urandom_range(2, 79), PHASE_ITEMS, 1'b1);
        run_random_traffic(7'd127, PHASE_ITEMS, 1'b1);
        run_random_traffic(7'd7, PHASE_ITEMS, 1'b1);
        run_random_traffic(7'd33, PHASE_ITEMS, 1'b0);

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
